// ----- hdl/bcpd_pkg.sv -----
// Package for the button click-pattern detector.
// Holds slot and gesture codes, register indexes, reset values and the pattern match.
// No dependencies.
package bcpd_pkg;

  // Number of press slots kept for one gesture.
  localparam int MAX_PRESSES = 3;
  localparam int PATTERN_COUNT = 7;

  // Widths fixed by the item fields and the register map.
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int GESTURE_W = 3;
  localparam int SLOT_IDX_W = 2;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(MAX_PRESSES - 1);

  // Class of one press as stored in a slot.
  typedef enum logic [1:0] {
    SLOT_NONE     = 2'd0,
    SLOT_SHORT    = 2'd1,
    SLOT_LONG     = 2'd2,
    SLOT_OVERLONG = 2'd3
  } slot_t;

  // Gesture codes given out with each result item.
  localparam logic [GESTURE_W-1:0] GESTURE_NONE     = 3'd0;
  localparam logic [GESTURE_W-1:0] GESTURE_NO_MATCH = 3'd7;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SHORT_MIN = 2'd0,
    REG_LONG_MIN  = 2'd1,
    REG_LONG_MAX  = 2'd2,
    REG_IDLE_WAIT = 2'd3
  } reg_idx_t;

  // Register reset values.
  localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd10;
  localparam logic [CFG_W-1:0] LONG_MIN_RST  = 16'd800;
  localparam logic [CFG_W-1:0] LONG_MAX_RST  = 16'd2500;
  localparam logic [CFG_W-1:0] IDLE_WAIT_RST = 16'd400;

  typedef slot_t slot_row_t [MAX_PRESSES];

  // Fixed patterns; the position in the list is the gesture code.
  localparam slot_t PATTERNS [PATTERN_COUNT][MAX_PRESSES] = '{
    '{SLOT_NONE,  SLOT_NONE,  SLOT_NONE },
    '{SLOT_SHORT, SLOT_NONE,  SLOT_NONE },
    '{SLOT_SHORT, SLOT_SHORT, SLOT_NONE },
    '{SLOT_SHORT, SLOT_LONG,  SLOT_NONE },
    '{SLOT_SHORT, SLOT_SHORT, SLOT_SHORT},
    '{SLOT_LONG,  SLOT_NONE,  SLOT_NONE },
    '{SLOT_LONG,  SLOT_SHORT, SLOT_NONE }
  };

  // Compares the slots against every pattern; the first match in the list wins.
  function automatic logic [GESTURE_W-1:0] match_slots(input slot_row_t slots);
    logic [GESTURE_W-1:0] code;
    code = GESTURE_NO_MATCH;
    for (int p = PATTERN_COUNT - 1; p >= 0; p--) begin
      if (slots[0] == PATTERNS[p][0] && slots[1] == PATTERNS[p][1] &&
          slots[2] == PATTERNS[p][2]) begin
        code = GESTURE_W'(p);
      end
    end
    return code;
  endfunction

endpackage

// ----- hdl/bcpd_in_if.sv -----
// Sample channel of the button click-pattern detector: timestamp and raw pin level.
// Depends on bcpd_pkg.
interface bcpd_in_if import bcpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic              level;

  modport source (output valid, now_ms, level, input ready);
  modport sink (input valid, now_ms, level, output ready);
endinterface

// ----- hdl/bcpd_out_if.sv -----
// Result channel of the button click-pattern detector: gesture code and evaluation flag.
// Depends on bcpd_pkg.
interface bcpd_out_if import bcpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [GESTURE_W-1:0] gesture;
  logic                 evaluated;

  modport source (output valid, gesture, evaluated, input ready);
  modport sink (input valid, gesture, evaluated, output ready);
endinterface

// ----- hdl/button_click_pattern_detector_top.sv -----
// Top level of the button click-pattern detector with its APB register port.
// Depends on bcpd_pkg, bcpd_in_if and bcpd_out_if.

// The block takes one sample item per clock cycle while results are taken and
// returns exactly one result item for each, in the cycle after the sample is
// accepted. All the work for a sample (debounce, press timing, classing, idle wait
// and the seven-pattern match) is done combinationally between the state registers
// and the result register, which alone sets the rate, and a sample is still
// accepted in the cycle its waiting result leaves. gesture is 0 whenever
// evaluated is 0. The user must write registers through APB only while no item
// is in flight; the block itself does not enforce it. pready is always high.
module button_click_pattern_detector_top import bcpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  bcpd_in_if.sink            samples,
  bcpd_out_if.source         results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Configuration registers.
  logic [CFG_W-1:0] short_min_ms;
  logic [CFG_W-1:0] long_min_ms;
  logic [CFG_W-1:0] long_max_ms;
  logic [CFG_W-1:0] idle_wait_ms;

  // Detector state.
  logic [1:0]            debounce_count;
  logic                  pressed;
  logic [TIME_W-1:0]     press_start;
  slot_row_t             press_slots;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [TIME_W-1:0]     idle_deadline;

  // Next values.
  logic [1:0]            debounce_count_next;
  logic                  pressed_next;
  logic [TIME_W-1:0]     press_start_next;
  slot_row_t             press_slots_next;
  logic [SLOT_IDX_W-1:0] slot_index_next;
  logic [TIME_W-1:0]     idle_deadline_next;
  logic [GESTURE_W-1:0]  gesture_next;
  logic                  evaluated_next;

  // Working values of one step.
  logic                  low;
  logic                  accept;
  logic [TIME_W-1:0]     dur;
  slot_t                 cls;
  logic [SLOT_IDX_W-1:0] idx;
  logic [SLOT_IDX_W-1:0] idx_adv;
  reg_idx_t              reg_sel;
  logic                  cfg_write;

  // Result register.
  logic                 res_valid;
  logic [GESTURE_W-1:0] res_gesture;
  logic                 res_evaluated;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register writes; only the low half of the data word is kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_min_ms <= SHORT_MIN_RST;
      long_min_ms  <= LONG_MIN_RST;
      long_max_ms  <= LONG_MAX_RST;
      idle_wait_ms <= IDLE_WAIT_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_SHORT_MIN: short_min_ms <= pwdata[CFG_W-1:0];
        REG_LONG_MIN:  long_min_ms  <= pwdata[CFG_W-1:0];
        REG_LONG_MAX:  long_max_ms  <= pwdata[CFG_W-1:0];
        REG_IDLE_WAIT: idle_wait_ms <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_SHORT_MIN: prdata = PDATA_W'(short_min_ms);
      REG_LONG_MIN:  prdata = PDATA_W'(long_min_ms);
      REG_LONG_MAX:  prdata = PDATA_W'(long_max_ms);
      REG_IDLE_WAIT: prdata = PDATA_W'(idle_wait_ms);
      default:       prdata = '0;
    endcase
  end

  // A sample is taken whenever the result register is free or being emptied.
  assign samples.ready = !res_valid || results.ready;
  assign accept        = samples.valid && samples.ready;
  assign low           = !samples.level;

  // One full step of the detector for the sample on the channel.
  always_comb begin
    debounce_count_next = debounce_count;
    pressed_next        = pressed;
    press_start_next    = press_start;
    press_slots_next    = press_slots;
    slot_index_next     = slot_index;
    idle_deadline_next  = idle_deadline;
    gesture_next        = GESTURE_NONE;
    evaluated_next      = 1'b0;
    dur                 = '0;
    cls                 = SLOT_NONE;

    // Debounce: three low samples fill the counter, the fourth presses.
    if (debounce_count != 2'd3) begin
      debounce_count_next = low ? debounce_count + 2'd1 : 2'd0;
    end else if (low) begin
      pressed_next = 1'b1;
    end else begin
      debounce_count_next = 2'd0;
      pressed_next        = 1'b0;
    end

    // Press timing; a start time of zero means no press is being timed.
    if (pressed_next) begin
      if (press_start == '0) begin
        press_start_next = samples.now_ms;
      end
    end else if (press_start != '0) begin
      dur              = samples.now_ms - press_start;
      press_start_next = '0;
    end

    // Class the press: short, then long, then over-long, else none.
    if (dur >= TIME_W'(short_min_ms) && dur < TIME_W'(long_min_ms)) begin
      cls = SLOT_SHORT;
    end else if (dur >= TIME_W'(long_min_ms) && dur <= TIME_W'(long_max_ms)) begin
      cls = SLOT_LONG;
    end else if (dur > TIME_W'(long_max_ms)) begin
      cls = SLOT_OVERLONG;
    end

    // Store the class; the index stops at the last slot.
    idx     = (slot_index > LAST_SLOT) ? LAST_SLOT : slot_index;
    idx_adv = (cls != SLOT_NONE && idx != LAST_SLOT) ? idx + SLOT_IDX_W'(1) : idx;
    if (dur != '0) begin
      press_slots_next[idx] = cls;
      slot_index_next       = idx_adv;
    end

    // Idle wait after release, then match and clear the slots.
    if (!pressed_next) begin
      if (idle_deadline == '0) begin
        idle_deadline_next = samples.now_ms + TIME_W'(idle_wait_ms);
      end
      if (samples.now_ms > idle_deadline_next) begin
        gesture_next     = match_slots(press_slots_next);
        evaluated_next   = 1'b1;
        press_slots_next = '{default: SLOT_NONE};
        slot_index_next  = '0;
      end
    end else begin
      idle_deadline_next = '0;
    end
  end

  // State registers advance on each accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= 2'd0;
      pressed        <= 1'b0;
      press_start    <= '0;
      press_slots    <= '{default: SLOT_NONE};
      slot_index     <= '0;
      idle_deadline  <= '0;
    end else if (accept) begin
      debounce_count <= debounce_count_next;
      pressed        <= pressed_next;
      press_start    <= press_start_next;
      press_slots    <= press_slots_next;
      slot_index     <= slot_index_next;
      idle_deadline  <= idle_deadline_next;
    end
  end

  // Result register: loaded on accept, emptied when the sink takes the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_gesture   <= gesture_next;
      res_evaluated <= evaluated_next;
    end
  end

  assign results.valid     = res_valid;
  assign results.gesture   = res_gesture;
  assign results.evaluated = res_evaluated;

endmodule

// ----- hdl/bcpd_checker.sv -----
// Port-level checks for the button click-pattern detector, bound to its top level.
// Depends on bcpd_pkg and button_click_pattern_detector_top.
module bcpd_checker import bcpd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [GESTURE_W-1:0] gesture,
  input logic                 evaluated
);

  // The result register is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // An accepted item always yields a result in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item produced no result");

  // With no result waiting the block must take items.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A step that did not evaluate reports no gesture.
  a_gesture_needs_eval: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evaluated) |-> (gesture == GESTURE_NONE))
    else $error("gesture given without evaluation");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(gesture) && $stable(evaluated)))
    else $error("stalled result changed");

endmodule

bind button_click_pattern_detector_top bcpd_checker u_bcpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .gesture   (results.gesture),
  .evaluated (results.evaluated)
);
